FILE: rtl/core/dlfc_pkg.sv
// Shared types, field widths, status codes and control structs of the d-left flow counter.
`default_nettype none
package dlfc_pkg;

	// field widths
	localparam int KEY_W    = 31;
	localparam int MOD_W    = 7;
	localparam int CNT_W    = 32;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [MOD_W-1:0]    mod_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [STATUS_W-1:0] status_t;

	// result status codes
	localparam status_t ST_HIT = 2'd0;
	localparam status_t ST_NEW = 2'd1;
	localparam status_t ST_REJ = 2'd2;

	localparam cnt_t CNT_MAX = '1;

	// controller to datapath commands
	typedef struct packed {
		logic key_ld;
		logic mul_en;
		logic red_en;
		logic hash_en;
		logic rd_en;
		logic commit;
		logic clr_en;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic clr_last;
	} sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/dlfc_ctrl.sv
// Sequencer for the flow counter: clearing sweep, request steps and output handshake.
`default_nettype none
module dlfc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output dlfc_pkg::cmd_t     cmd,
	input  wire dlfc_pkg::sts_t sts
);

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_RED    = 3'd3;
	localparam logic [2:0] S_HASH   = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_DECIDE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       commit;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	// result register is free or being drained this cycle
	assign commit    = (state_q == S_DECIDE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:   if (accept) state_d = S_MUL;
			S_MUL:    state_d = S_RED;
			S_RED:    state_d = S_HASH;
			S_HASH:   state_d = S_READ;
			S_READ:   state_d = S_DECIDE;
			S_DECIDE: if (commit) state_d = S_IDLE;
			default:  state_d = S_CLEAR;
		endcase
	end

	// commands
	always_comb begin
		cmd         = '0;
		cmd.clr_en  = (state_q == S_CLEAR);
		cmd.key_ld  = accept;
		cmd.mul_en  = (state_q == S_MUL);
		cmd.red_en  = (state_q == S_RED);
		cmd.hash_en = (state_q == S_HASH);
		cmd.rd_en   = (state_q == S_READ);
		cmd.commit  = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/dlfc_dp.sv
// Datapath: hash units, banked way memories, hit/insert selection and result registers.
`default_nettype none
module dlfc_dp #(
	parameter int WAYS        = 4,
	parameter int SUB_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire dlfc_pkg::mod_t    cfg_wr_data,
	input  wire dlfc_pkg::key_t    flow_key,
	input  wire dlfc_pkg::cmd_t    cmd,
	output dlfc_pkg::sts_t         sts,
	output dlfc_pkg::status_t      status,
	output dlfc_pkg::slot_t        slot_index,
	output dlfc_pkg::cnt_t         entry_count,
	output dlfc_pkg::cnt_t         flow_total
);

	localparam int IW    = (SUB_ENTRIES > 1) ? $clog2(SUB_ENTRIES) : 1;
	localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W = dlfc_pkg::KEY_W + dlfc_pkg::CNT_W;
	// reciprocal for the key modulo: floor(2^SH / N) fits 32 bits
	localparam int SH             = 31 + $clog2(SUB_ENTRIES);
	localparam logic [63:0] RCP_W = (64'd1 << SH) / SUB_ENTRIES;
	localparam logic [31:0] RECIP = RCP_W[31:0];
	localparam logic [IW:0] N_E   = (IW+1)'(SUB_ENTRIES);
	localparam logic [IW-1:0] LAST_IDX = IW'(SUB_ENTRIES - 1);

	dlfc_pkg::mod_t  mod_q;
	dlfc_pkg::key_t  key_q;
	logic [62:0]     prod_q;
	logic [IW:0]     r_q;
	logic [IW-1:0]   h_q    [WAYS];
	dlfc_pkg::slot_t slot_q [WAYS];
	logic [ENT_W-1:0] rd_q  [WAYS];
	logic [IW-1:0]   clr_idx_q;
	dlfc_pkg::cnt_t  total_q;

	dlfc_pkg::status_t status_q;
	dlfc_pkg::slot_t   slot_out_q;
	dlfc_pkg::cnt_t    count_out_q;
	dlfc_pkg::cnt_t    total_out_q;

	// low byte residues, built at elaboration
	logic [IW-1:0] lo_mod [256];
	for (genvar i = 0; i < 256; i++) begin : g_lo_mod
		assign lo_mod[i] = IW'(i % SUB_ENTRIES);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= '0;
		end else if (cfg_wr_en) begin
			mod_q <= cfg_wr_data;
		end
	end

	// high key part modulo N: multiply by reciprocal, then one correction later
	logic [30:0] key_hi;
	logic [30:0] quot;
	logic [30:0] qn;
	logic [30:0] rem_full;
	assign key_hi   = {key_q[30:8], 8'h00};
	assign quot     = 31'(prod_q >> SH);
	assign qn       = quot * 31'(SUB_ENTRIES);
	assign rem_full = key_hi - qn;

	// per way slot: fold in the low byte after XOR with modifier plus way
	logic [IW:0]   a_full;
	logic [IW-1:0] a_red;
	logic [IW-1:0] h_d    [WAYS];
	dlfc_pkg::slot_t slot_d [WAYS];
	always_comb begin
		logic [7:0]  mix;
		logic [7:0]  lo;
		logic [IW:0] sum;
		a_full = (r_q >= N_E) ? (r_q - N_E) : r_q;
		a_red  = a_full[IW-1:0];
		for (int d = 0; d < WAYS; d++) begin
			mix = {1'b0, mod_q} + 8'(d);
			lo  = key_q[7:0] ^ mix;
			sum = {1'b0, a_red} + {1'b0, lo_mod[lo]};
			if (sum >= N_E) begin
				sum = sum - N_E;
			end
			h_d[d]    = sum[IW-1:0];
			slot_d[d] = dlfc_pkg::slot_t'(d * SUB_ENTRIES) + dlfc_pkg::slot_t'(sum[IW-1:0]);
		end
	end

	// request registers
	always_ff @(posedge clk) begin
		if (cmd.key_ld) begin
			key_q <= flow_key;
		end
		if (cmd.mul_en) begin
			prod_q <= {32'b0, key_hi} * {31'b0, RECIP};
		end
		if (cmd.red_en) begin
			r_q <= rem_full[IW:0];
		end
		if (cmd.hash_en) begin
			for (int d = 0; d < WAYS; d++) begin
				h_q[d]    <= h_d[d];
				slot_q[d] <= slot_d[d];
			end
		end
	end

	// hit and insert selection, leftmost way wins
	logic          hit_found;
	logic          emp_found;
	logic [WW-1:0] hit_sel;
	logic [WW-1:0] emp_sel;
	logic [WW-1:0] sel;
	logic          found;
	dlfc_pkg::cnt_t old_cnt;
	dlfc_pkg::cnt_t new_cnt;
	dlfc_pkg::cnt_t new_total;
	always_comb begin
		hit_found = 1'b0;
		emp_found = 1'b0;
		hit_sel   = '0;
		emp_sel   = '0;
		for (int d = WAYS - 1; d >= 0; d--) begin
			if (rd_q[d][ENT_W-1 -: dlfc_pkg::KEY_W] == key_q) begin
				hit_found = 1'b1;
				hit_sel   = WW'(d);
			end
			if (rd_q[d][ENT_W-1 -: dlfc_pkg::KEY_W] == '0) begin
				emp_found = 1'b1;
				emp_sel   = WW'(d);
			end
		end
		// a zero key would match empty slots; it is always rejected
		if (key_q == '0) begin
			hit_found = 1'b0;
			emp_found = 1'b0;
		end
		sel     = hit_found ? hit_sel : emp_sel;
		found   = hit_found || emp_found;
		old_cnt = rd_q[sel][dlfc_pkg::CNT_W-1:0];
		if (hit_found) begin
			new_cnt = (old_cnt == dlfc_pkg::CNT_MAX) ? old_cnt : old_cnt + 1'b1;
		end else begin
			new_cnt = dlfc_pkg::cnt_t'(1);
		end
		new_total = (total_q == dlfc_pkg::CNT_MAX) ? total_q : total_q + 1'b1;
	end

	// way banks: one write port, one registered read port each
	for (genvar d = 0; d < WAYS; d++) begin : g_way
		logic [ENT_W-1:0] mem [SUB_ENTRIES];
		logic             we;
		logic [IW-1:0]    waddr;
		logic [ENT_W-1:0] wdata;
		assign we    = cmd.clr_en || (cmd.commit && found && (sel == WW'(d)));
		assign waddr = cmd.clr_en ? clr_idx_q : h_q[d];
		assign wdata = cmd.clr_en ? '0 : {key_q, new_cnt};
		always_ff @(posedge clk) begin
			if (we) begin
				mem[waddr] <= wdata;
			end
			if (cmd.rd_en) begin
				rd_q[d] <= mem[h_q[d]];
			end
		end
	end

	// clearing sweep index
	assign sts.clr_last = (clr_idx_q == LAST_IDX);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_en) begin
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	// global total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (cmd.commit && found) begin
			total_q <= new_total;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (found) begin
				status_q    <= hit_found ? dlfc_pkg::ST_HIT : dlfc_pkg::ST_NEW;
				slot_out_q  <= slot_q[sel];
				count_out_q <= new_cnt;
				total_out_q <= new_total;
			end else begin
				status_q    <= dlfc_pkg::ST_REJ;
				slot_out_q  <= '0;
				count_out_q <= '0;
				total_out_q <= total_q;
			end
		end
	end

	assign status      = status_q;
	assign slot_index  = slot_out_q;
	assign entry_count = count_out_q;
	assign flow_total  = total_out_q;

endmodule
`default_nettype wire

FILE: rtl/core/d_left_flow_counter_core.sv
// Top level of the d-left flow counter: controller plus datapath.
// Counts requests per flow key in a d-left hash table of WAYS banks of SUB_ENTRIES
// slots each; each request gets one result with status, slot, entry count and the
// running total. Between acceptance and the loading of its result, the key modulo
// uses a reciprocal multiply and a constant multiply in two steps, one step forms
// all way slots, one step reads every bank in parallel and the last one picks the
// hit or the leftmost empty slot and writes back. The next request is accepted in
// the cycle after the result is loaded, even while it waits on out_stall, so a new
// request is not taken before the last one is through; a result held by out_stall
// only delays the write back of the following request. After reset a clearing pass
// zeroes all banks, one row per cycle, and in_stall stays high meanwhile; the
// base_modifier writes are taken at any time.
`default_nettype none
module d_left_flow_counter_core #(
	parameter int WAYS        = 4,
	parameter int SUB_ENTRIES = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire dlfc_pkg::mod_t    cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire dlfc_pkg::key_t    flow_key,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output dlfc_pkg::status_t      status,
	output dlfc_pkg::slot_t        slot_index,
	output dlfc_pkg::cnt_t         entry_count,
	output dlfc_pkg::cnt_t         flow_total
);

	dlfc_pkg::cmd_t cmd;
	dlfc_pkg::sts_t sts;

	dlfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	dlfc_dp #(
		.WAYS        (WAYS),
		.SUB_ENTRIES (SUB_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.flow_key    (flow_key),
		.cmd         (cmd),
		.sts         (sts),
		.status      (status),
		.slot_index  (slot_index),
		.entry_count (entry_count),
		.flow_total  (flow_total)
	);

endmodule
`default_nettype wire

FILE: rtl/core/dlfc_chk.sv
// Port-level checker for the flow counter and its bind to the top level.
`default_nettype none
module dlfc_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire dlfc_pkg::status_t status,
	input wire dlfc_pkg::slot_t   slot_index,
	input wire dlfc_pkg::cnt_t    entry_count,
	input wire dlfc_pkg::cnt_t    flow_total
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_index)
			&& $stable(entry_count) && $stable(flow_total))
		else $error("stalled result changed");

	// one request at a time: the cycle after acceptance the input is stalled
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request accepted while busy");

	// only defined status codes leave the block
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == dlfc_pkg::ST_HIT) || (status == dlfc_pkg::ST_NEW)
			|| (status == dlfc_pkg::ST_REJ))
		else $error("undefined status");

	// rejected requests report zero slot and count
	a_rej_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dlfc_pkg::ST_REJ) |-> (slot_index == '0) && (entry_count == '0))
		else $error("rejected result with nonzero slot or count");

	// a fresh entry starts at one and the total has moved past zero
	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == dlfc_pkg::ST_NEW) |-> (entry_count == 32'd1) && (flow_total != '0))
		else $error("new entry with wrong count or total");

endmodule

bind d_left_flow_counter_core dlfc_chk u_dlfc_chk (.*);
`default_nettype wire
